@@ hw/rtl/bltb_pkg.sv @@
// bltb_pkg: shared widths, codes and types of the based literal converter
// no dependencies; imported by the channel interfaces and every module
package bltb_pkg;

   localparam int WORD_W        = 64;
   localparam int CHAR_W        = 8;
   localparam int SIZE_W        = 7;
   localparam int DIGIT_W       = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 7;
   localparam int MAX_WIDTH_DEF = 64;
   localparam int GRP_W         = 16;
   localparam int GRP_N         = WORD_W / GRP_W;
   localparam int GRP_POS_W     = $clog2(GRP_W);
   localparam int GRP_IDX_W     = $clog2(GRP_N);
   localparam int WORD_IDX_W    = $clog2(WORD_W);

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd32;

   typedef enum logic [1:0] {
      BASE_BIN = 2'd0,
      BASE_OCT = 2'd1,
      BASE_DEC = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUMBER_BASE  = 2'd0,
      REG_IS_SIGNED    = 2'd1,
      REG_LITERAL_SIZE = 2'd2
   } csr_reg_type;

   typedef enum logic [2:0] {
      OP_SKIP  = 3'd0,
      OP_BAD   = 3'd1,
      OP_DIGIT = 3'd2,
      OP_UNK   = 3'd3,
      OP_HIZ   = 3'd4
   } op_kind_type;

   typedef struct packed {
      base_type          number_base;
      logic              is_signed;
      logic [SIZE_W-1:0] literal_size;
   } cfg_type;

   // one classified character, front to back
   typedef struct packed {
      op_kind_type        kind;
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } char_op_type;

   // accumulated literal at its last character
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] x_mask;
      logic [WORD_W-1:0] z_mask;
      logic [SIZE_W-1:0] length;
      logic              bad;
   } acc_snap_type;

endpackage

@@ hw/rtl/bltb_if.sv @@
// bltb_if: valid/ready channel interfaces for characters, results and register writes
// depends on bltb_pkg
interface bltb_req_if;
   import bltb_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last_char;
   modport source (output valid, digit_char, last_char, input ready);
   modport sink   (input valid, digit_char, last_char, output ready);
endinterface

interface bltb_rsp_if;
   import bltb_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] bit_value;
   logic [WORD_W-1:0] unknown_mask;
   logic [WORD_W-1:0] highz_mask;
   logic              invalid;
   modport source (output valid, bit_value, unknown_mask, highz_mask, invalid, input ready);
   modport sink   (input valid, bit_value, unknown_mask, highz_mask, invalid, output ready);
endinterface

interface bltb_csr_if;
   import bltb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bltb_front.sv @@
// bltb_front: character classifier and two-entry op queue
// depends on bltb_pkg
module bltb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  bltb_pkg::base_type        number_base,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [bltb_pkg::CHAR_W-1:0] digit_char,
   input  logic                      last_char,
   output logic                      op_valid,
   output bltb_pkg::char_op_type     op,
   input  logic                      op_ready
);
   import bltb_pkg::*;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_QUESTION   = 8'h3F;
   localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_F    = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_F    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LOWER_X    = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UPPER_X    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;

   char_op_type        q_mem [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   logic               push, pop;
   logic               is_num, is_hex, is_x, is_z, digit_ok;
   logic [DIGIT_W-1:0] dval;
   char_op_type        new_op;

   // classify the incoming character
   always_comb begin
      is_num = (digit_char >= CH_ZERO) && (digit_char <= CH_NINE);
      is_hex = is_num
         || ((digit_char >= CH_LOWER_A) && (digit_char <= CH_LOWER_F))
         || ((digit_char >= CH_UPPER_A) && (digit_char <= CH_UPPER_F));
      is_x   = (digit_char == CH_LOWER_X) || (digit_char == CH_UPPER_X);
      is_z   = (digit_char == CH_LOWER_Z) || (digit_char == CH_UPPER_Z)
         || (digit_char == CH_QUESTION);
      dval   = is_num ? digit_char[DIGIT_W-1:0] : digit_char[DIGIT_W-1:0] + 4'd9;

      unique case (number_base)
         BASE_BIN: digit_ok = is_hex && (dval[DIGIT_W-1:1] == 3'd0);
         BASE_OCT: digit_ok = is_hex && !dval[DIGIT_W-1];
         BASE_DEC: digit_ok = is_num;
         BASE_HEX: digit_ok = is_hex;
         default:  digit_ok = 1'b0;
      endcase

      new_op.digit = dval;
      new_op.last  = last_char;
      if (digit_char == CH_UNDERSCORE) begin
         new_op.kind = OP_SKIP;
      end else if (number_base != BASE_DEC && is_x) begin
         new_op.kind = OP_UNK;
      end else if (number_base != BASE_DEC && is_z) begin
         new_op.kind = OP_HIZ;
      end else if (digit_ok) begin
         new_op.kind = OP_DIGIT;
      end else begin
         new_op.kind = OP_BAD;
      end
   end

   assign req_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign op_valid  = (count_ff != '0);
   assign op        = q_mem[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("op queue count above depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("op queue count missed a push");
`endif

endmodule

@@ hw/rtl/bltb_accum.sv @@
// bltb_accum: back-end accumulator, shifts in digit chunks or does value*10+digit
// depends on bltb_pkg
module bltb_accum #(
   parameter int MAX_WIDTH = bltb_pkg::MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bltb_pkg::base_type     number_base,
   input  logic                   op_valid,
   input  bltb_pkg::char_op_type  op,
   output logic                   op_ready,
   output logic                   snap_valid,
   output bltb_pkg::acc_snap_type snap,
   input  logic                   snap_ready
);
   import bltb_pkg::*;

   localparam logic [SIZE_W:0] LEN_SAT = (SIZE_W+1)'(MAX_WIDTH + 1);

   logic [WORD_W-1:0] value_ff, value_in;
   logic [WORD_W-1:0] x_mask_ff, x_mask_in;
   logic [WORD_W-1:0] z_mask_ff, z_mask_in;
   logic [SIZE_W-1:0] length_ff, length_in;
   logic              bad_ff, bad_in;

   logic [WORD_W-1:0] sh_value, sh_x, sh_z, chunk_mask;
   logic [2:0]        chunk;
   logic [SIZE_W:0]   len_sum;
   logic [SIZE_W-1:0] len_next;
   logic              pop;

   always_comb begin
      unique case (number_base)
         BASE_BIN: begin
            chunk      = 3'd1;
            chunk_mask = WORD_W'(4'h1);
         end
         BASE_OCT: begin
            chunk      = 3'd3;
            chunk_mask = WORD_W'(4'h7);
         end
         BASE_HEX: begin
            chunk      = 3'd4;
            chunk_mask = WORD_W'(4'hF);
         end
         default: begin
            chunk      = 3'd0;
            chunk_mask = '0;
         end
      endcase

      sh_value = value_ff << chunk;
      sh_x     = x_mask_ff << chunk;
      sh_z     = z_mask_ff << chunk;
      len_sum  = {1'b0, length_ff} + (SIZE_W+1)'(chunk);
      len_next = (len_sum > LEN_SAT) ? LEN_SAT[SIZE_W-1:0] : len_sum[SIZE_W-1:0];

      value_in  = value_ff;
      x_mask_in = x_mask_ff;
      z_mask_in = z_mask_ff;
      length_in = length_ff;
      bad_in    = bad_ff;

      case (op.kind)
         OP_BAD: bad_in = 1'b1;
         OP_DIGIT: begin
            if (number_base == BASE_DEC) begin
               // wraps modulo 2^64
               value_in = (value_ff << 3) + (value_ff << 1) + WORD_W'(op.digit);
            end else begin
               value_in  = sh_value | WORD_W'(op.digit);
               x_mask_in = sh_x;
               z_mask_in = sh_z;
               length_in = len_next;
            end
         end
         OP_UNK: begin
            value_in  = sh_value;
            x_mask_in = sh_x | chunk_mask;
            z_mask_in = sh_z;
            length_in = len_next;
         end
         OP_HIZ: begin
            value_in  = sh_value;
            x_mask_in = sh_x;
            z_mask_in = sh_z | chunk_mask;
            length_in = len_next;
         end
         default: ;
      endcase
   end

   assign snap_valid  = op_valid && op.last;
   assign op_ready    = !op.last || snap_ready;
   assign pop         = op_valid && op_ready;
   assign snap.value  = value_in;
   assign snap.x_mask = x_mask_in;
   assign snap.z_mask = z_mask_in;
   assign snap.length = length_in;
   assign snap.bad    = bad_in;

   always_ff @(posedge clock) begin
      if (reset || (pop && op.last)) begin
         value_ff  <= '0;
         x_mask_ff <= '0;
         z_mask_ff <= '0;
         length_ff <= '0;
         bad_ff    <= 1'b0;
      end else if (pop) begin
         value_ff  <= value_in;
         x_mask_ff <= x_mask_in;
         z_mask_ff <= z_mask_in;
         length_ff <= length_in;
         bad_ff    <= bad_in;
      end
   end

`ifndef SYNTH
   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_SAT[SIZE_W-1:0])
      else $error("accumulated length above saturation");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && op.last) |=> (value_ff == '0 && x_mask_ff == '0 && z_mask_ff == '0
                            && length_ff == '0 && !bad_ff))
      else $error("accumulator not cleared after literal end");
`endif

endmodule

@@ hw/rtl/bltb_finish.sv @@
// bltb_finish: length search, size fit and sign padding, then the result register
// depends on bltb_pkg
module bltb_finish #(
   parameter int MAX_WIDTH = bltb_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bltb_pkg::cfg_type             cfg,
   input  logic                          snap_valid,
   input  bltb_pkg::acc_snap_type        snap,
   output logic                          snap_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bltb_pkg::WORD_W-1:0]   bit_value,
   output logic [bltb_pkg::WORD_W-1:0]   unknown_mask,
   output logic [bltb_pkg::WORD_W-1:0]   highz_mask,
   output logic                          invalid
);
   import bltb_pkg::*;

   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_WIDTH);

   logic                 s1_valid_ff, s1_valid_in;
   acc_snap_type         s1_ff;
   logic                 s2_valid_ff, s2_valid_in;
   acc_snap_type         s2_ff;
   logic                 grp_any_ff [GRP_N];
   logic [GRP_POS_W-1:0] grp_pos_ff [GRP_N];
   logic                 grp_any_in [GRP_N];
   logic [GRP_POS_W-1:0] grp_pos_in [GRP_N];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    bit_value_ff, bit_value_in;
   logic [WORD_W-1:0]    unknown_mask_ff, unknown_mask_in;
   logic [WORD_W-1:0]    highz_mask_ff, highz_mask_in;
   logic                 invalid_ff;

   logic                  out_free, s2_free;
   logic [WORD_IDX_W-1:0] lead;
   logic [SIZE_W-1:0]     len, size, len_m1;
   logic [WORD_IDX_W-1:0] top;
   logic [WORD_W-1:0]     keep, pad;
   logic                  do_pad;

   // stall chain, output back to input
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign snap_ready = !s1_valid_ff || s2_free;

   always_comb begin
      s1_valid_in  = snap_ready ? snap_valid : s1_valid_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
   end

   // leading one per 16-bit group of the value
   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         grp_any_in[g] = 1'b0;
         grp_pos_in[g] = '0;
         for (int i = 0; i < GRP_W; i++) begin
            if (s1_ff.value[g*GRP_W + i]) begin
               grp_any_in[g] = 1'b1;
               grp_pos_in[g] = GRP_POS_W'(i);
            end
         end
      end
   end

   // fit to size and pad
   always_comb begin
      lead = '0;
      for (int g = 0; g < GRP_N; g++) begin
         if (grp_any_ff[g]) begin
            lead = {GRP_IDX_W'(g), grp_pos_ff[g]};
         end
      end
      len = (cfg.number_base == BASE_DEC) ? SIZE_W'(lead) + 1'b1 : s2_ff.length;

      if (cfg.literal_size == '0) begin
         size = SIZE_W'(1);
      end else if (cfg.literal_size > SIZE_MAX) begin
         size = SIZE_MAX;
      end else begin
         size = cfg.literal_size;
      end

      for (int i = 0; i < WORD_W; i++) begin
         keep[i] = SIZE_W'(i) < size;
         pad[i]  = (SIZE_W'(i) < size) && (SIZE_W'(i) >= len);
      end

      do_pad = cfg.is_signed && (len != '0) && (len < size);
      len_m1 = len - 1'b1;
      top    = len_m1[WORD_IDX_W-1:0];

      bit_value_in    = s2_ff.value & keep;
      unknown_mask_in = s2_ff.x_mask & keep;
      highz_mask_in   = s2_ff.z_mask & keep;
      if (do_pad) begin
         if (s2_ff.x_mask[top]) begin
            unknown_mask_in = unknown_mask_in | pad;
         end else if (s2_ff.z_mask[top]) begin
            highz_mask_in = highz_mask_in | pad;
         end else if (s2_ff.value[top]) begin
            bit_value_in = bit_value_in | pad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_ready) begin
         s1_ff <= snap;
      end
      if (s2_free) begin
         s2_ff <= s1_ff;
         for (int g = 0; g < GRP_N; g++) begin
            grp_any_ff[g] <= grp_any_in[g];
            grp_pos_ff[g] <= grp_pos_in[g];
         end
      end
      if (out_free) begin
         bit_value_ff    <= bit_value_in;
         unknown_mask_ff <= unknown_mask_in;
         highz_mask_ff   <= highz_mask_in;
         invalid_ff      <= s2_ff.bad;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign bit_value    = bit_value_ff;
   assign unknown_mask = unknown_mask_ff;
   assign highz_mask   = highz_mask_ff;
   assign invalid      = invalid_ff;

`ifndef SYNTH
   a_above_size_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((bit_value_ff | unknown_mask_ff | highz_mask_ff) & ~keep) == '0))
      else $error("result bits set above literal size");
`endif

endmodule

@@ hw/rtl/based_literal_to_bits_unit.sv @@
// based_literal_to_bits_unit: sized based-literal converter, one character per transaction
// throughput: one character per cycle unless stalled; accumulator does one shift or *10+digit add
// per cycle, and the result path (group leading-one, size fit, pad) is a three-register pipe
// reset: synchronous, clears queue, accumulators and pipe valids; base binary, unsigned, size 32
// depends on bltb_pkg, bltb_if, bltb_front, bltb_accum, bltb_finish
module based_literal_to_bits_unit #(
   parameter int MAX_WIDTH = bltb_pkg::MAX_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   bltb_req_if.sink    req_bus,
   bltb_rsp_if.source  rsp_bus,
   bltb_csr_if.sink    csr_bus
);
   import bltb_pkg::*;

   // configuration registers
   cfg_type      cfg_ff, cfg_in;

   // front to back
   logic         op_valid, op_ready;
   char_op_type  op;

   // accumulator to result pipe
   logic         snap_valid, snap_ready;
   acc_snap_type snap;

   // register writes are always taken; users must write only while idle; the block does not check
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_reg_type'(csr_bus.index))
            REG_NUMBER_BASE:  cfg_in.number_base  = base_type'(csr_bus.data[1:0]);
            REG_IS_SIGNED:    cfg_in.is_signed    = csr_bus.data[0];
            REG_LITERAL_SIZE: cfg_in.literal_size = csr_bus.data[SIZE_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.number_base  <= BASE_BIN;
         cfg_ff.is_signed    <= 1'b0;
         cfg_ff.literal_size <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify each character and queue it
   bltb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .number_base (cfg_ff.number_base),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .digit_char  (req_bus.digit_char),
      .last_char   (req_bus.last_char),
      .op_valid    (op_valid),
      .op          (op),
      .op_ready    (op_ready)
   );

   // back: build the bit vector, hand it off on the last character
   bltb_accum #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .number_base (cfg_ff.number_base),
      .op_valid    (op_valid),
      .op          (op),
      .op_ready    (op_ready),
      .snap_valid  (snap_valid),
      .snap        (snap),
      .snap_ready  (snap_ready)
   );

   // result pipe: length, size fit, sign padding, output register
   bltb_finish #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_finish (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .snap_valid   (snap_valid),
      .snap         (snap),
      .snap_ready   (snap_ready),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .bit_value    (rsp_bus.bit_value),
      .unknown_mask (rsp_bus.unknown_mask),
      .highz_mask   (rsp_bus.highz_mask),
      .invalid      (rsp_bus.invalid)
   );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for based_literal_to_bits_unit, directed table then random literals
// depends on bltb_pkg, bltb_if and the unit itself
module tb_top;
   import bltb_pkg::*;

   // character codes with a meaning of their own
   localparam logic [CHAR_W-1:0] CH_SKIP = "_";
   localparam logic [CHAR_W-1:0] CH_ANY  = "?";
   localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TOP  = 8'hFF;

   // quiet cycles after the last result before touching registers or ending
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_CHARS  = 1500;
   localparam int DIR_N         = 24;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] x_mask;
      logic [WORD_W-1:0] z_mask;
      logic              invalid;
   } lit_result_type;

   // one row of the directed table: the setting it needs, the character, and an
   // optional hand-written result that replaces the predicted one
   typedef struct {
      base_type          base;
      bit                sgn;
      logic [SIZE_W-1:0] size;
      logic [CHAR_W-1:0] ch;
      bit                last;
      bit                typed;
      lit_result_type    exp;
   } char_row_type;

   localparam lit_result_type NO_EXP = '{default: '0};

   logic clock;
   logic reset;

   bltb_req_if req_bus ();
   bltb_rsp_if rsp_bus ();
   bltb_csr_if csr_bus ();

   based_literal_to_bits_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // register copy, at reset values
   base_type          cfg_base   = BASE_BIN;
   bit                cfg_signed = 1'b0;
   logic [SIZE_W-1:0] cfg_size   = SIZE_RESET;

   // literal being accumulated
   logic [WORD_W-1:0] acc_val = '0;
   logic [WORD_W-1:0] acc_x   = '0;
   logic [WORD_W-1:0] acc_z   = '0;
   int                acc_len = 0;
   bit                acc_bad = 1'b0;

   lit_result_type literal_results_due[$];
   int             mismatch_count = 0;
   int             chars_sent     = 0;
   bit             req_no_idle    = 1'b0;
   bit             rsp_no_idle    = 1'b0;
   bit             hold_off_req   = 1'b0;

   char_row_type dir_rows [DIR_N] = '{
      // empty literal straight after reset, reset setting untouched
      '{BASE_BIN, 1'b0, 7'd32, CH_SKIP, 1'b1, 1'b1, NO_EXP},
      // signed one-bit literals pad with their only bit, known, x or z
      '{BASE_BIN, 1'b1, 7'd8, "1", 1'b1, 1'b1, '{64'hFF, 64'h0, 64'h0, 1'b0}},
      '{BASE_BIN, 1'b1, 7'd8, "x", 1'b1, 1'b1, '{64'h0, 64'hFF, 64'h0, 1'b0}},
      '{BASE_BIN, 1'b1, 7'd8, CH_ANY, 1'b1, 1'b1, '{64'h0, 64'h0, 64'hFF, 1'b0}},
      // empty literal stays zero when signed
      '{BASE_BIN, 1'b1, 7'd8, CH_SKIP, 1'b1, 1'b1, NO_EXP},
      // top character code is illegal in hex
      '{BASE_HEX, 1'b0, 7'd64, CH_TOP, 1'b1, 1'b1, '{64'h0, 64'h0, 64'h0, 1'b1}},
      // hex with upper/lower case digits and both unknown kinds
      '{BASE_HEX, 1'b0, 7'd64, "F", 1'b0, 1'b0, NO_EXP},
      '{BASE_HEX, 1'b0, 7'd64, "a", 1'b0, 1'b0, NO_EXP},
      '{BASE_HEX, 1'b0, 7'd64, "Z", 1'b0, 1'b0, NO_EXP},
      '{BASE_HEX, 1'b0, 7'd64, "X", 1'b1, 1'b0, NO_EXP},
      // smallest size keeps one bit; size zero acts as one
      '{BASE_OCT, 1'b0, 7'd1, "7", 1'b1, 1'b1, '{64'h1, 64'h0, 64'h0, 1'b0}},
      '{BASE_OCT, 1'b0, 7'd0, "z", 1'b1, 1'b1, '{64'h0, 64'h0, 64'h1, 1'b0}},
      // octal has no digit eight; the literal still completes
      '{BASE_OCT, 1'b1, 7'd16, "8", 1'b0, 1'b0, NO_EXP},
      '{BASE_OCT, 1'b1, 7'd16, "4", 1'b1, 1'b0, NO_EXP},
      // size above the word acts as the full word
      '{BASE_DEC, 1'b0, 7'd127, "9", 1'b1, 1'b1, '{64'h9, 64'h0, 64'h0, 1'b0}},
      // decimal sign comes from the top bit of the shortest binary form
      '{BASE_DEC, 1'b1, 7'd8, "5", 1'b1, 1'b0, NO_EXP},
      '{BASE_DEC, 1'b1, 7'd8, "0", 1'b1, 1'b1, NO_EXP},
      // unknown digit in decimal is illegal
      '{BASE_DEC, 1'b0, 7'd32, "x", 1'b1, 1'b1, '{64'h0, 64'h0, 64'h0, 1'b1}},
      // base changed in the middle of one literal
      '{BASE_HEX, 1'b0, 7'd32, "a", 1'b0, 1'b0, NO_EXP},
      '{BASE_BIN, 1'b0, 7'd32, "1", 1'b0, 1'b0, NO_EXP},
      '{BASE_DEC, 1'b0, 7'd32, "3", 1'b1, 1'b0, NO_EXP},
      // control character is illegal, underscore carries the last mark
      '{BASE_BIN, 1'b0, 7'd32, CH_NUL, 1'b0, 1'b0, NO_EXP},
      '{BASE_BIN, 1'b0, 7'd32, "1", 1'b0, 1'b0, NO_EXP},
      '{BASE_BIN, 1'b0, 7'd32, CH_SKIP, 1'b1, 1'b0, NO_EXP}
   };

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------ predictor
   function automatic logic [WORD_W-1:0] low_mask(int n);
      if (n >= WORD_W) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   // hex value of a character, 16 when it is no hex digit
   function automatic int hex_value(logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return 16;
   endfunction

   // fold one character into the accumulated literal
   function automatic void fold_char(logic [CHAR_W-1:0] c);
      int                d;
      int                chunk;
      bit                is_x;
      bit                is_z;
      logic [WORD_W-1:0] cm;
      d    = hex_value(c);
      is_x = (c == "x" || c == "X");
      is_z = (c == "z" || c == "Z" || c == CH_ANY);
      if (c == CH_SKIP) return;
      if (cfg_base == BASE_DEC) begin
         if (d >= 10) acc_bad = 1'b1;
         else acc_val = acc_val * 64'd10 + 64'(d);
         return;
      end
      chunk = (cfg_base == BASE_BIN) ? 1 : (cfg_base == BASE_OCT) ? 3 : 4;
      if (!is_x && !is_z && d >= (1 << chunk)) begin
         acc_bad = 1'b1;
         return;
      end
      cm = low_mask(chunk);
      acc_val = acc_val << chunk;
      acc_x   = acc_x << chunk;
      acc_z   = acc_z << chunk;
      if (is_x) acc_x = acc_x | cm;
      else if (is_z) acc_z = acc_z | cm;
      else acc_val = acc_val | 64'(d);
      acc_len = acc_len + chunk;
      if (acc_len > MAX_WIDTH_DEF + 1) acc_len = MAX_WIDTH_DEF + 1;
   endfunction

   // fit the accumulated bits to the declared size and clear the accumulator
   function automatic lit_result_type close_literal();
      lit_result_type    r;
      int                sz;
      int                len;
      logic [WORD_W-1:0] keep;
      logic [WORD_W-1:0] pad;
      logic [WORD_W-1:0] top;
      logic [WORD_W-1:0] t;
      sz = int'(cfg_size);
      if (sz < 1) sz = 1;
      if (sz > MAX_WIDTH_DEF) sz = MAX_WIDTH_DEF;
      len = acc_len;
      if (cfg_base == BASE_DEC) begin
         // decimal length is that of the shortest binary form, one bit for zero
         len = 1;
         t   = acc_val;
         while (t > 64'd1) begin
            t = t >> 1;
            len++;
         end
      end
      keep      = low_mask(sz);
      r.value   = acc_val & keep;
      r.x_mask  = acc_x & keep;
      r.z_mask  = acc_z & keep;
      r.invalid = acc_bad;
      if (len < sz && len > 0 && cfg_signed) begin
         pad = keep & ~low_mask(len);
         top = 64'd1 << (len - 1);
         if ((acc_x & top) != '0) r.x_mask = r.x_mask | pad;
         else if ((acc_z & top) != '0) r.z_mask = r.z_mask | pad;
         else if ((acc_val & top) != '0) r.value = r.value | pad;
      end
      acc_val = '0;
      acc_x   = '0;
      acc_z   = '0;
      acc_len = 0;
      acc_bad = 1'b0;
      return r;
   endfunction

   // --------------------------------------------------------- stimulus aids
   function automatic int draw_gap(bit no_idle);
      if (no_idle || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // mostly legal digits of the base, some unknowns, skips and raw noise
   function automatic logic [CHAR_W-1:0] gen_char(base_type b);
      int unsigned r;
      int unsigned d;
      r = $urandom_range(0, 99);
      if (r < 6) return CHAR_W'($urandom_range(0, 255));
      if (r < 10) return CH_SKIP;
      if (r < 16) begin
         case ($urandom_range(0, 4))
            0: return "x";
            1: return "X";
            2: return "z";
            3: return "Z";
            default: return CH_ANY;
         endcase
      end
      case (b)
         BASE_BIN: d = $urandom_range(0, 1);
         BASE_OCT: d = $urandom_range(0, 7);
         BASE_DEC: d = $urandom_range(0, 9);
         default:  d = $urandom_range(0, 15);
      endcase
      if (d < 10) return CHAR_W'(int'("0") + d);
      if ($urandom_range(0, 1) == 0) return CHAR_W'(int'("a") + d - 10);
      return CHAR_W'(int'("A") + d - 10);
   endfunction

   // widths skewed to the edges: zero, one, full word and beyond
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'd64;
         3: return 7'd65;
         4: return 7'd127;
         default: return SIZE_W'($urandom_range(1, 64));
      endcase
   endfunction

   // one character transaction; the handshake is sampled at the rising edge
   task automatic send_char(logic [CHAR_W-1:0] c, bit last, int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.digit_char <= c;
      req_bus.last_char  <= last;
      do @(posedge clock); while (!req_bus.ready);
      chars_sent++;
      fold_char(c);
      if (last) literal_results_due = {literal_results_due, close_literal()};
   endtask

   task automatic send_literal(int n);
      for (int i = 0; i < n; i++) send_char(gen_char(cfg_base), i == n - 1, draw_gap(req_no_idle));
   endtask

   // stop offering, wait for every result, then let the block go quiet
   task automatic drain_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (literal_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_NUMBER_BASE:  cfg_base = base_type'(data[1:0]);
         REG_IS_SIGNED:    cfg_signed = data[0];
         REG_LITERAL_SIZE: cfg_size = data[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   // drain, then write every register that differs (or all of them)
   task automatic write_config(base_type b, bit s, logic [SIZE_W-1:0] z, bit all);
      bit wrote;
      wrote = 1'b0;
      drain_block();
      if (all || b != cfg_base) begin
         write_reg(REG_NUMBER_BASE, CSR_DATA_W'(b));
         wrote = 1'b1;
      end
      if (all || s != cfg_signed) begin
         write_reg(REG_IS_SIGNED, CSR_DATA_W'(s));
         wrote = 1'b1;
      end
      if (all || z != cfg_size) begin
         write_reg(REG_LITERAL_SIZE, CSR_DATA_W'(z));
         wrote = 1'b1;
      end
      if (wrote) begin
         @(negedge clock);
         csr_bus.valid <= 1'b0;
      end
   endtask

   // ------------------------------------------------------------- stimulus
   initial begin : stim
      int phase;
      int target;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.digit_char = '0;
      req_bus.last_char  = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_NUMBER_BASE;
      csr_bus.data       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; a setting change mid-literal exercises mixed bases
      for (int i = 0; i < DIR_N; i++) begin
         if (dir_rows[i].base != cfg_base || dir_rows[i].sgn != cfg_signed ||
             dir_rows[i].size != cfg_size)
            write_config(dir_rows[i].base, dir_rows[i].sgn, dir_rows[i].size, 1'b0);
         send_char(dir_rows[i].ch, dir_rows[i].last, draw_gap(1'b0));
         // the result is still on its way through the pipe, so the tail entry is still ours
         if (dir_rows[i].last && dir_rows[i].typed)
            literal_results_due[$] = dir_rows[i].exp;
      end

      // random phases, each under a fresh setting
      phase  = 0;
      target = chars_sent + RANDOM_CHARS;
      while (chars_sent < target) begin
         write_config(base_type'($urandom_range(0, 3)), bit'($urandom_range(0, 1)),
                      pick_size(), 1'b1);
         req_no_idle = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            // receiver stalls long while single-character literals pour in
            hold_off_req = 1'b1;
            repeat (60) send_char(gen_char(cfg_base), 1'b1, 0);
         end else begin
            repeat ($urandom_range(10, 40)) begin
               if ($urandom_range(0, 3) == 0) send_literal($urandom_range(1, 24));
               else send_literal($urandom_range(1, 8));
            end
         end
         phase++;
      end

      drain_block();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ------------------------------------------------------- result receiver
   // draws a wait before each result; one long hold when asked for
   initial begin : rsp_drive
      int wait_cycles;
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            wait_cycles  = HOLD_CYCLES;
         end else begin
            wait_cycles = draw_gap(rsp_no_idle);
         end
         // flip between idling and no-idling stretches now and then
         if ($urandom_range(0, 39) == 0) rsp_no_idle = !rsp_no_idle;
         if (wait_cycles > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready && !reset));
      end
   end

   // ---------------------------------------------------------------- checker
   // every accepted result transaction is matched against the oldest prediction
   always @(posedge clock) begin
      lit_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (literal_results_due.size() == 0) begin
            $error("result transaction with no literal outstanding");
            mismatch_count++;
         end else begin
            want = literal_results_due.pop_front();
            if (rsp_bus.bit_value !== want.value) begin
               $error("bit_value expected %h got %h", want.value, rsp_bus.bit_value);
               mismatch_count++;
            end
            if (rsp_bus.unknown_mask !== want.x_mask) begin
               $error("unknown_mask expected %h got %h", want.x_mask, rsp_bus.unknown_mask);
               mismatch_count++;
            end
            if (rsp_bus.highz_mask !== want.z_mask) begin
               $error("highz_mask expected %h got %h", want.z_mask, rsp_bus.highz_mask);
               mismatch_count++;
            end
            if (rsp_bus.invalid !== want.invalid) begin
               $error("invalid expected %b got %b", want.invalid, rsp_bus.invalid);
               mismatch_count++;
            end
         end
      end
   end

endmodule

@@ sim.f @@
hw/rtl/bltb_pkg.sv
hw/rtl/bltb_if.sv
hw/rtl/bltb_front.sv
hw/rtl/bltb_accum.sv
hw/rtl/bltb_finish.sv
hw/rtl/based_literal_to_bits_unit.sv
tb/sv/tb_top.sv
